// ===== src/record_deque_macros.svh =====
// ============================================================================
// Record deque assertion macros
// Shared concurrent assertion forms used by the record deque RTL.
// ============================================================================
`ifndef RECORD_DEQUE_MACROS_SVH
`define RECORD_DEQUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record_deque: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record_deque: next-cycle check failed");

`endif

// ===== src/rdq_pkg.sv =====
// ============================================================================
// Record deque package
// Types, operation codes and status codes shared by the record deque RTL.
// ============================================================================
`timescale 1ns / 1ps

package rdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int POS_W         = 7;

   // Operation requested by a transaction.
   localparam logic [2:0] MODE_LIST       = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_BACK   = 3'd2;
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd3;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd4;

   // Result status.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Command broadcast to every cell of the chain.
   typedef logic [2:0] cell_op_type;
   localparam cell_op_type OP_HOLD       = 3'd0;
   localparam cell_op_type OP_LOAD       = 3'd1;  // write the pushed record at the back
   localparam cell_op_type OP_SHIFT_UP   = 3'd2;  // move every entry one place back
   localparam cell_op_type OP_SHIFT_DOWN = 3'd3;  // move every entry one place forward
   localparam cell_op_type OP_ROTATE     = 3'd4;  // front entry wraps to the back

   typedef struct packed {
      logic [15:0] roll_number;
      logic [63:0] name_low;
      logic [15:0] name_high;
      logic [39:0] branch_text;
      logic [3:0]  semester;
      logic [9:0]  mark;
   } record_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] roll_number;
      logic [63:0] name_low;
      logic [15:0] name_high;
      logic [39:0] branch_text;
      logic [3:0]  semester;
      logic [9:0]  mark;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] position;
      logic [15:0]      out_roll_number;
      logic [63:0]      out_name_low;
      logic [15:0]      out_name_high;
      logic [39:0]      out_branch_text;
      logic [3:0]       out_semester;
      logic [9:0]       out_mark;
      logic [POS_W-1:0] occupancy;
      logic             last;
   } rsp_type;

endpackage

// ===== src/rdq_cell.sv =====
// ============================================================================
// Record deque cell
// One place of the chain; loads from a neighbor, the pushed or the front record.
// ============================================================================
`timescale 1ns / 1ps

module rdq_cell #(
   parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  rdq_pkg::cell_op_type op,
   input  logic [CW-1:0]       count,
   input  rdq_pkg::record_type push_rec,
   input  rdq_pkg::record_type front_rec,
   input  rdq_pkg::record_type back_rec,
   input  rdq_pkg::record_type head_rec,
   output rdq_pkg::record_type rec
);

   rdq_pkg::record_type rec_ff;
   rdq_pkg::record_type rec_in;
   logic                is_free_slot;
   logic                is_tail;

   // This cell is the first free place, or the last occupied one.
   assign is_free_slot = (count == CW'(INDEX));
   assign is_tail      = (count == CW'(INDEX + 1));

   always_comb begin
      rec_in = rec_ff;
      case (op)
         rdq_pkg::OP_LOAD: begin
            if (is_free_slot) begin
               rec_in = push_rec;
            end
         end
         rdq_pkg::OP_SHIFT_UP:   rec_in = front_rec;
         rdq_pkg::OP_SHIFT_DOWN: rec_in = back_rec;
         rdq_pkg::OP_ROTATE:     rec_in = is_tail ? head_rec : back_rec;
         default:                rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

// ===== src/record_deque.sv =====
// ============================================================================
// Record deque
// Bounded double-ended queue of student records held in a chain of cells.
// ============================================================================
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  rdq_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  rdq_pkg::rsp_type
//
// A push or pop loads the result register at the edge that accepts the
// transaction, and the cells shift in that same edge. A list first enters
// the list state, then emits one result per entry while the result side is
// free; the front cell is read and the chain rotates once per emitted result.
// Reset clears the count and the control state; the record cells hold no
// reset value and are only read after they were written.
// A stalled result holds the result register and blocks new transactions.
//
// The records live in DEPTH identical cells ordered front (cell 0) to back.
// Push front shifts the chain one place back and enters the new record at
// cell 0; pop front shifts it one place forward. Push back writes the first
// free cell, and pop back reads the last occupied one. Listing emits cell 0
// and rotates the occupied part of the chain, so after all entries have been
// emitted the chain is back in its original order.

`timescale 1ns / 1ps

module record_deque #(
   parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rdq_pkg::rsp_type rsp_data
);

`include "record_deque_macros.svh"

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic                 state_ff;
   logic                 state_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [CW-1:0]        list_idx_ff;
   logic [CW-1:0]        list_idx_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rdq_pkg::rsp_type     rsp_data_ff;
   rdq_pkg::rsp_type     rsp_data_in;
   logic                 rsp_load;

   logic                 req_fire;
   logic                 rsp_free;
   logic                 is_full;
   logic                 is_empty;
   logic [CW-1:0]        list_pos;
   rdq_pkg::cell_op_type cell_op;
   rdq_pkg::record_type  push_rec;
   rdq_pkg::record_type  head_rec;
   rdq_pkg::record_type  tail_rec;
   rdq_pkg::record_type  cell_rec [DEPTH];

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign list_pos  = list_idx_ff + CW'(1);

   assign push_rec.roll_number = req_data.roll_number;
   assign push_rec.name_low    = req_data.name_low;
   assign push_rec.name_high   = req_data.name_high;
   assign push_rec.branch_text = req_data.branch_text;
   assign push_rec.semester    = req_data.semester;
   assign push_rec.mark        = req_data.mark;

   // ------------------------------------------------------------------------
   // Cell chain. Each cell sees its two neighbors and the front record.
   // ------------------------------------------------------------------------
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         rdq_pkg::record_type front_nb;
         rdq_pkg::record_type back_nb;

         if (gi == 0) begin : g_first
            assign front_nb = push_rec;
         end else begin : g_mid
            assign front_nb = cell_rec[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_last
            assign back_nb = '0;
         end else begin : g_inner
            assign back_nb = cell_rec[gi+1];
         end

         rdq_cell #(
            .DEPTH (DEPTH),
            .INDEX (gi),
            .CW    (CW)
         ) u_cell (
            .clock     (clock),
            .op        (cell_op),
            .count     (count_ff),
            .push_rec  (push_rec),
            .front_rec (front_nb),
            .back_rec  (back_nb),
            .head_rec  (head_rec),
            .rec       (cell_rec[gi])
         );
      end
   endgenerate

   assign head_rec = cell_rec[0];

   // The back entry is picked by a one-hot match on the count.
   always_comb begin
      tail_rec = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (count_ff == CW'(i + 1)) begin
            tail_rec = tail_rec | cell_rec[i];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Control: decode the accepted transaction, or step through a list.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      list_idx_in  = list_idx_ff;
      cell_op      = rdq_pkg::OP_HOLD;
      rsp_load     = 1'b0;
      rsp_data_in  = '0;
      rsp_data_in.last = 1'b1;

      if (state_ff == ST_IDLE) begin
         if (req_fire) begin
            case (req_data.mode)
               rdq_pkg::MODE_LIST: begin
                  if (is_empty) begin
                     rsp_load           = 1'b1;
                     rsp_data_in.status = rdq_pkg::STATUS_EMPTY;
                  end else begin
                     state_in    = ST_LIST;
                     list_idx_in = '0;
                  end
               end
               rdq_pkg::MODE_PUSH_BACK, rdq_pkg::MODE_PUSH_FRONT: begin
                  rsp_load = 1'b1;
                  if (is_full) begin
                     rsp_data_in.status    = rdq_pkg::STATUS_FULL;
                     rsp_data_in.occupancy = rdq_pkg::POS_W'(count_ff);
                  end else begin
                     count_in = count_ff + CW'(1);
                     cell_op  = (req_data.mode == rdq_pkg::MODE_PUSH_BACK) ?
                                rdq_pkg::OP_LOAD : rdq_pkg::OP_SHIFT_UP;
                     rsp_data_in.status    = rdq_pkg::STATUS_OK;
                     rsp_data_in.occupancy = rdq_pkg::POS_W'(count_in);
                  end
               end
               rdq_pkg::MODE_POP_BACK, rdq_pkg::MODE_POP_FRONT: begin
                  rsp_load = 1'b1;
                  if (is_empty) begin
                     rsp_data_in.status = rdq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - CW'(1);
                     if (req_data.mode == rdq_pkg::MODE_POP_FRONT) begin
                        cell_op                     = rdq_pkg::OP_SHIFT_DOWN;
                        rsp_data_in.out_roll_number = head_rec.roll_number;
                        rsp_data_in.out_name_low    = head_rec.name_low;
                        rsp_data_in.out_name_high   = head_rec.name_high;
                        rsp_data_in.out_branch_text = head_rec.branch_text;
                        rsp_data_in.out_semester    = head_rec.semester;
                        rsp_data_in.out_mark        = head_rec.mark;
                     end else begin
                        rsp_data_in.out_roll_number = tail_rec.roll_number;
                        rsp_data_in.out_name_low    = tail_rec.name_low;
                        rsp_data_in.out_name_high   = tail_rec.name_high;
                        rsp_data_in.out_branch_text = tail_rec.branch_text;
                        rsp_data_in.out_semester    = tail_rec.semester;
                        rsp_data_in.out_mark        = tail_rec.mark;
                     end
                     rsp_data_in.status    = rdq_pkg::STATUS_OK;
                     rsp_data_in.occupancy = rdq_pkg::POS_W'(count_in);
                  end
               end
               default: begin
                  // Unused codes are consumed without a result.
                  rsp_load = 1'b0;
               end
            endcase
         end
      end else begin
         if (rsp_free) begin
            rsp_load                    = 1'b1;
            cell_op                     = rdq_pkg::OP_ROTATE;
            rsp_data_in.status          = rdq_pkg::STATUS_OK;
            rsp_data_in.position        = rdq_pkg::POS_W'(list_pos);
            rsp_data_in.out_roll_number = head_rec.roll_number;
            rsp_data_in.out_name_low    = head_rec.name_low;
            rsp_data_in.out_name_high   = head_rec.name_high;
            rsp_data_in.out_branch_text = head_rec.branch_text;
            rsp_data_in.out_semester    = head_rec.semester;
            rsp_data_in.out_mark        = head_rec.mark;
            rsp_data_in.occupancy       = rdq_pkg::POS_W'(count_ff);
            rsp_data_in.last            = (list_pos == count_ff);
            if (list_pos == count_ff) begin
               state_in    = ST_IDLE;
               list_idx_in = '0;
            end else begin
               list_idx_in = list_pos;
            end
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         list_idx_ff  <= list_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset; it is only shown while valid.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `RDQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `RDQ_ASSERT_NOW(a_list_idx_bound, clock, reset, state_ff == ST_LIST,
                   list_idx_ff < count_ff)
   `RDQ_ASSERT_NOW(a_inner_result_in_list, clock, reset,
                   rsp_valid_ff && !rsp_data_ff.last, state_ff == ST_LIST)
   `RDQ_ASSERT_NEXT(a_full_push_drops, clock, reset,
                    req_fire && is_full && (req_data.mode == rdq_pkg::MODE_PUSH_BACK ||
                    req_data.mode == rdq_pkg::MODE_PUSH_FRONT),
                    count_ff == CW'(DEPTH) && rsp_data_ff.status == rdq_pkg::STATUS_FULL)

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// Record deque testbench
// Drives list, push and pop transactions at both ends of the deque. A
// directed sequence of transactions covers the empty store, the full store
// and all-ones and all-zeros records. A longer random sequence then fills
// and drains the store over and over. Every returned record, count and
// status is checked against a typed result or an independent deque model.
// ============================================================================
`timescale 1ns / 1ps

module tb;

   localparam int RING_DEPTH   = rdq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 225;
   // A list of a full store is the longest burst of results after the last request.
   localparam int DRAIN_CYCLES = RING_DEPTH + 8;

   // Mode values outside the five operations; the block must ignore them.
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   // One row of stimulus. When the expected result is obvious it is typed
   // into the row; otherwise the deque model supplies it.
   typedef struct {
      rdq_pkg::req_type req;
      bit               typed;
      rdq_pkg::rsp_type rsp;
   } stim_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   rdq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rdq_pkg::rsp_type rsp_data;

   record_deque dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Deque model: a ring of records with a front slot and an entry count.
   rdq_pkg::record_type ring_records [RING_DEPTH];
   int                  front_slot = 0;
   int                  held_count = 0;

   // Results from the latest modeled transaction, and results still owed by the block.
   rdq_pkg::rsp_type step_results[$];
   rdq_pkg::rsp_type pending_results[$];

   int mismatch_count = 0;

   // Idle rates, in percent, for the request side and the response side.
   int send_idle_pct = 14;
   int stall_pct     = 82;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rdq_pkg::rsp_type make_result(logic [1:0] status, int pos,
                                                    rdq_pkg::record_type rec,
                                                    int occupancy, bit is_last);
      rdq_pkg::rsp_type r;
      r.status          = status;
      r.position        = pos[rdq_pkg::POS_W-1:0];
      r.out_roll_number = rec.roll_number;
      r.out_name_low    = rec.name_low;
      r.out_name_high   = rec.name_high;
      r.out_branch_text = rec.branch_text;
      r.out_semester    = rec.semester;
      r.out_mark        = rec.mark;
      r.occupancy       = occupancy[rdq_pkg::POS_W-1:0];
      r.last            = is_last;
      return r;
   endfunction

   // Works out the results of one accepted transaction and updates the model.
   function automatic void predict_deque_results(input rdq_pkg::req_type r);
      rdq_pkg::record_type rec;
      int                  slot;
      rec = {r.roll_number, r.name_low, r.name_high, r.branch_text, r.semester, r.mark};
      step_results.delete();
      case (r.mode)
         rdq_pkg::MODE_LIST: begin
            if (held_count == 0) begin
               step_results.push_back(make_result(rdq_pkg::STATUS_EMPTY, 0, '0, 0, 1'b1));
            end else begin
               for (int i = 0; i < held_count; i++) begin
                  step_results.push_back(make_result(rdq_pkg::STATUS_OK, i + 1,
                     ring_records[(front_slot + i) % RING_DEPTH], held_count,
                     i == held_count - 1));
               end
            end
         end
         rdq_pkg::MODE_PUSH_BACK, rdq_pkg::MODE_PUSH_FRONT: begin
            if (held_count >= RING_DEPTH) begin
               // A push into a full store is dropped.
               step_results.push_back(make_result(rdq_pkg::STATUS_FULL, 0, '0,
                                                  held_count, 1'b1));
            end else begin
               if (r.mode == rdq_pkg::MODE_PUSH_BACK) begin
                  ring_records[(front_slot + held_count) % RING_DEPTH] = rec;
               end else begin
                  front_slot = (front_slot + RING_DEPTH - 1) % RING_DEPTH;
                  ring_records[front_slot] = rec;
               end
               held_count++;
               step_results.push_back(make_result(rdq_pkg::STATUS_OK, 0, '0,
                                                  held_count, 1'b1));
            end
         end
         rdq_pkg::MODE_POP_BACK, rdq_pkg::MODE_POP_FRONT: begin
            if (held_count == 0) begin
               step_results.push_back(make_result(rdq_pkg::STATUS_EMPTY, 0, '0, 0, 1'b1));
            end else begin
               if (r.mode == rdq_pkg::MODE_POP_BACK) begin
                  slot = (front_slot + held_count - 1) % RING_DEPTH;
               end else begin
                  slot = front_slot;
                  front_slot = (front_slot + 1) % RING_DEPTH;
               end
               held_count--;
               step_results.push_back(make_result(rdq_pkg::STATUS_OK, 0, ring_records[slot],
                                                  held_count, 1'b1));
            end
         end
         default: begin
            // Spare modes produce nothing and leave the store alone.
         end
      endcase
   endfunction

   function automatic stim_row_type directed_row(logic [2:0] mode, rdq_pkg::record_type rec,
                                                 bit typed, rdq_pkg::rsp_type rsp);
      stim_row_type row;
      row.req   = {mode, rec};
      row.typed = typed;
      row.rsp   = rsp;
      return row;
   endfunction

   // Random record, with an all-ones or all-zeros record now and then.
   function automatic rdq_pkg::record_type random_record();
      logic [159:0] bits;
      int           pick;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(7);
      if (pick == 0) begin
         bits = '1;
      end else if (pick == 1) begin
         bits = '0;
      end
      return bits[149:0];
   endfunction

   // Presents one transaction, optionally after a random gap, and waits until
   // the block takes it. Valid stays high between back-to-back transactions.
   task automatic send_request(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row.req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The transaction was accepted at this edge.
      predict_deque_results(row.req);
      if (row.typed) begin
         pending_results.push_back(row.rsp);
      end else begin
         foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
   endtask

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // The response side stalls at random; the rate changes with the test phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Every accepted result is compared with the oldest one still owed.
   always @(posedge clock) begin
      rdq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_data.status));
            check_field("position", 64'(want.position), 64'(rsp_data.position));
            check_field("roll_number", 64'(want.out_roll_number),
                        64'(rsp_data.out_roll_number));
            check_field("name_low", want.out_name_low, rsp_data.out_name_low);
            check_field("name_high", 64'(want.out_name_high), 64'(rsp_data.out_name_high));
            check_field("branch_text", 64'(want.out_branch_text),
                        64'(rsp_data.out_branch_text));
            check_field("semester", 64'(want.out_semester), 64'(rsp_data.out_semester));
            check_field("mark", 64'(want.out_mark), 64'(rsp_data.out_mark));
            check_field("occupancy", 64'(want.occupancy), 64'(rsp_data.occupancy));
            check_field("last", 64'(want.last), 64'(rsp_data.last));
         end
      end
   end

   initial begin
      stim_row_type        directed_rows[$];
      stim_row_type        row;
      rdq_pkg::record_type rec;
      logic [2:0]          mode;
      int                  spare_mode;
      int                  sent;
      int                  pick;
      bit                  filling;

      // Operations on the empty store after reset.
      directed_rows.push_back(directed_row(rdq_pkg::MODE_LIST, '0, 1'b1,
                              make_result(rdq_pkg::STATUS_EMPTY, 0, '0, 0, 1'b1)));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_POP_BACK, '0, 1'b1,
                              make_result(rdq_pkg::STATUS_EMPTY, 0, '0, 0, 1'b1)));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_POP_FRONT, '0, 1'b1,
                              make_result(rdq_pkg::STATUS_EMPTY, 0, '0, 0, 1'b1)));
      // An all-ones record at the back and an all-zeros record at the front,
      // then a list and a pop of the all-ones record.
      directed_rows.push_back(directed_row(rdq_pkg::MODE_PUSH_BACK, '1, 1'b1,
                              make_result(rdq_pkg::STATUS_OK, 0, '0, 1, 1'b1)));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_PUSH_FRONT, '0, 1'b1,
                              make_result(rdq_pkg::STATUS_OK, 0, '0, 2, 1'b1)));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_LIST, '0, 1'b0, '0));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_POP_BACK, '0, 1'b0, '0));
      // Fill the store from both ends, so the front wraps around the ring.
      for (int k = 2; k <= RING_DEPTH; k++) begin
         directed_rows.push_back(directed_row((k % 2 != 0) ? rdq_pkg::MODE_PUSH_BACK :
                                              rdq_pkg::MODE_PUSH_FRONT,
                                 random_record(), 1'b1,
                                 make_result(rdq_pkg::STATUS_OK, 0, '0, k, 1'b1)));
      end
      // Pushes into the full store are dropped at either end.
      directed_rows.push_back(directed_row(rdq_pkg::MODE_PUSH_BACK, '1, 1'b1,
                              make_result(rdq_pkg::STATUS_FULL, 0, '0, RING_DEPTH, 1'b1)));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_PUSH_FRONT, '1, 1'b1,
                              make_result(rdq_pkg::STATUS_FULL, 0, '0, RING_DEPTH, 1'b1)));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_LIST, '0, 1'b0, '0));
      directed_rows.push_back(directed_row(rdq_pkg::MODE_POP_FRONT, '0, 1'b0, '0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // Random part. The model's count steers the mix: while filling, most
      // transactions push; while draining, most pop. Lists and spare modes are
      // mixed in throughout. Spare modes do not count toward the total.
      sent    = 0;
      filling = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if (sent == RANDOM_ITEMS / 3) begin
            send_idle_pct = 82;
            stall_pct     = 14;
         end else if (sent == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         if (held_count == RING_DEPTH) begin
            filling = 1'b0;
         end else if (held_count == 0) begin
            filling = 1'b1;
         end else if ($urandom_range(39) == 0) begin
            filling = !filling;
         end
         rec  = random_record();
         pick = $urandom_range(99);
         if (pick < 4) begin
            spare_mode = $urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST);
            mode       = spare_mode[2:0];
         end else begin
            if (pick < 14) begin
               mode = rdq_pkg::MODE_LIST;
            end else if (($urandom_range(9) < 7) == filling) begin
               mode = $urandom_range(1) ? rdq_pkg::MODE_PUSH_BACK : rdq_pkg::MODE_PUSH_FRONT;
            end else begin
               mode = $urandom_range(1) ? rdq_pkg::MODE_POP_BACK : rdq_pkg::MODE_POP_FRONT;
            end
            sent++;
         end
         row = directed_row(mode, rec, 1'b0, '0);
         send_request(row);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("record_deque test passed");
      end else begin
         $display("record_deque test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("record_deque test failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/rdq_pkg.sv
src/rdq_cell.sv
src/record_deque.sv
tb/tb.sv
